// File: hdl/lcd_controller_regs_frame_timer_defines.svh
// assertion macros for the display controller register file and frame timer
// expects clk and rst_n in the scope where a macro is used
`ifndef LCD_CONTROLLER_REGS_FRAME_TIMER_DEFINES_SVH
`define LCD_CONTROLLER_REGS_FRAME_TIMER_DEFINES_SVH

// same-cycle implication
`define LCDFT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCDFT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lcdft_pkg.sv
// types, constants and lookup functions for the display controller frame timer
// no dependencies
package lcdft_pkg;

    // clock and counter scaling
    localparam int unsigned CPU_CLOCK_HZ      = 4000000;
    localparam int unsigned COUNTER_UNIT_RATE = 4680;

    localparam int CYC_W      = 16;
    localparam int FC_W       = 32;
    localparam int SCALE_SH   = 24;
    localparam int NUM_W      = CYC_W + SCALE_SH;
    localparam int RECIP_SH   = CYC_W;
    localparam longint unsigned RECIP =
        (64'd1 << (SCALE_SH + RECIP_SH)) / CPU_CLOCK_HZ;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int Q_W        = RECIP_W;
    // cycles times reciprocal
    localparam int P1_W       = CYC_W + RECIP_W;

    // frame counter landmarks
    localparam logic [FC_W-1:0] FC_RENDER   = 32'h1800_0000;
    localparam logic [7:0]      TOP_RENDER  = 8'h18;
    localparam logic [7:0]      TOP_COPY    = 8'h39;
    localparam logic [FC_W-1:0] FC_END      = 32'h4200_0000;
    localparam logic [FC_W-1:0] FC_RESTART  = 32'h0100_0000;

    localparam logic [7:0] SKIP_STEP     = 8'h10;
    localparam logic [7:0] MATCH_RESET   = 8'h10;
    localparam logic [7:0] MODE_MASK     = 8'h3F;
    localparam logic [7:0] MAP_LO_MASK   = 8'hF8;
    localparam logic [7:0] SPR_LO_MASK   = 8'hC0;
    localparam logic [7:0] HIGH_MASK     = 8'h1F;
    localparam logic [7:0] SCROLL_MASK   = 8'h7F;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        REG_MODE    = 4'd0,
        REG_RATE    = 4'd1,
        REG_MAP_LO  = 4'd2,
        REG_MAP_MID = 4'd3,
        REG_MAP_HI  = 4'd4,
        REG_SCR_Y   = 4'd5,
        REG_SCR_X   = 4'd6,
        REG_SPR_LO  = 4'd7,
        REG_SPR_MID = 4'd8,
        REG_SPR_HI  = 4'd9,
        REG_COUNTER = 4'd10
    } reg_idx_t;

    typedef enum logic [1:0] {
        DRAW_OFF  = 2'd0,
        DRAW_COPY = 2'd1,
        DRAW_FULL = 2'd2
    } draw_mode_t;

    typedef enum logic [1:0] {
        PH_CPU    = 2'd0,
        PH_RENDER = 2'd1,
        PH_COPY   = 2'd2
    } phase_t;

    // bus beat carried down the pipeline
    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] idx;
        logic [7:0] data;
    } bus_beat_t;

    // frame skip match value from rate bits 3..1
    function automatic logic [7:0] rate_match_lut(input logic [2:0] sel);
        logic [7:0] m;
        case (sel)
            3'd0:    m = 8'h20;
            3'd1:    m = 8'h50;
            3'd2:    m = 8'h80;
            3'd3:    m = 8'hB0;
            3'd4:    m = 8'h10;
            3'd5:    m = 8'h30;
            3'd6:    m = 8'h50;
            default: m = 8'h70;
        endcase
        return m;
    endfunction

endpackage

// File: hdl/lcd_controller_regs_frame_timer.sv
// display controller register file and frame sequencer, top level
// depends on lcdft_pkg and lcd_controller_regs_frame_timer_defines.svh
// a beat passes stages 0 to 3 and then the result register before its result is valid
// throughput: one beat per cycle while the result is taken; the tick increment runs through three
// multiply stages (scale, correction, unit rate) ahead of the state stage
// reset (rst_n, async, active low) clears the valids and all state, rate match to 0x10
`include "lcd_controller_regs_frame_timer_defines.svh"

module lcd_controller_regs_frame_timer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [3:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [15:0] cycles,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        cpu_stall,
    output logic        render_start,
    output logic        copy_start,
    output logic        frame_end_irq,
    output logic        lcd_refresh
);

    // ------------------------------------------------------------------
    // pipeline control: every stage moves together, gated by the result
    // register; a beat waiting at the output only stalls if it is not taken
    // ------------------------------------------------------------------
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    logic s0_vld_reg, s1_vld_reg, s2_vld_reg, s3_vld_reg, out_vld_reg;

    lcdft_pkg::bus_beat_t s0_beat_reg, s1_beat_reg, s2_beat_reg, s3_beat_reg;

    // stage 0: input register
    logic [lcdft_pkg::CYC_W-1:0] s0_cyc_reg;
    // stage 1: reciprocal estimate of cycles * 2^24 / clock
    logic [lcdft_pkg::CYC_W-1:0] s1_cyc_reg;
    logic [lcdft_pkg::Q_W-1:0]   s1_qest_reg;
    // stage 2: corrected quotient
    logic [lcdft_pkg::Q_W-1:0]   s2_q_reg;
    // stage 3: counter increment mod 2^32
    logic [lcdft_pkg::FC_W-1:0]  s3_inc_reg;

    // ------------------------------------------------------------------
    // increment datapath
    // ------------------------------------------------------------------
    logic [lcdft_pkg::P1_W-1:0]     s1_prod;
    logic [lcdft_pkg::Q_W-1:0]      s1_qest_next;
    assign s1_prod      = lcdft_pkg::P1_W'(s0_cyc_reg) * lcdft_pkg::P1_W'(lcdft_pkg::RECIP);
    assign s1_qest_next = s1_prod[lcdft_pkg::RECIP_SH +: lcdft_pkg::Q_W];

    // estimate is low by at most one; one compare fixes it
    logic [lcdft_pkg::NUM_W-1:0] s2_num, s2_prod, s2_rem;
    logic [lcdft_pkg::Q_W-1:0]   s2_q_next;
    assign s2_num  = {s1_cyc_reg, {lcdft_pkg::SCALE_SH{1'b0}}};
    assign s2_prod = lcdft_pkg::NUM_W'(s1_qest_reg)
                   * lcdft_pkg::NUM_W'(lcdft_pkg::CPU_CLOCK_HZ);
    assign s2_rem  = s2_num - s2_prod;
    assign s2_q_next = (s2_rem >= lcdft_pkg::NUM_W'(lcdft_pkg::CPU_CLOCK_HZ))
                     ? s1_qest_reg + lcdft_pkg::Q_W'(1) : s1_qest_reg;

    logic [lcdft_pkg::FC_W-1:0] s3_inc_next;
    assign s3_inc_next = lcdft_pkg::FC_W'(s2_q_reg)
                       * lcdft_pkg::FC_W'(lcdft_pkg::COUNTER_UNIT_RATE);

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg  <= in_valid;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    // stage payloads, no reset needed
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_beat_reg <= '{cmd: lcdft_pkg::cmd_t'(cmd), idx: reg_index, data: write_data};
            s0_cyc_reg  <= cycles;
            s1_beat_reg <= s0_beat_reg;
            s1_cyc_reg  <= s0_cyc_reg;
            s1_qest_reg <= s1_qest_next;
            s2_beat_reg <= s1_beat_reg;
            s2_q_reg    <= s2_q_next;
            s3_beat_reg <= s2_beat_reg;
            s3_inc_reg  <= s3_inc_next;
        end
    end

    // ------------------------------------------------------------------
    // register file and frame sequencer state, updated in the last stage
    // ------------------------------------------------------------------
    logic [5:0]                 mode_reg, mode_next;
    logic [7:0]                 rate_reg, rate_next;
    logic [7:0]                 match_reg, match_next;
    lcdft_pkg::draw_mode_t      draw_reg, draw_next;
    logic [20:0]                map_base_reg, map_base_next;
    logic [20:0]                spr_base_reg, spr_base_next;
    logic [6:0]                 scroll_y_reg, scroll_y_next;
    logic [6:0]                 scroll_x_reg, scroll_x_next;
    logic [lcdft_pkg::FC_W-1:0] fc_reg, fc_next;
    lcdft_pkg::phase_t          phase_reg, phase_next;
    logic                       stall_reg, stall_next;

    // result fields
    logic [7:0] rd_next;
    logic       render_next, copy_next, irq_next, refresh_next;

    logic [7:0] rd_reg;
    logic       render_reg, copy_reg, irq_reg, refresh_reg;

    logic [lcdft_pkg::FC_W-1:0] fc_sum;
    logic                       frame_active;
    logic [7:0]                 wdat;

    assign fc_sum       = fc_reg + s3_inc_reg;
    // a frame is drawn once the skip count reaches the match value
    assign frame_active = {rate_reg[7:4], 4'h0} >= match_reg;
    assign wdat         = s3_beat_reg.data;

    always_comb
    begin
        mode_next     = mode_reg;
        rate_next     = rate_reg;
        match_next    = match_reg;
        draw_next     = draw_reg;
        map_base_next = map_base_reg;
        spr_base_next = spr_base_reg;
        scroll_y_next = scroll_y_reg;
        scroll_x_next = scroll_x_reg;
        fc_next       = fc_reg;
        phase_next    = phase_reg;
        stall_next    = stall_reg;
        rd_next       = 8'h00;
        render_next   = 1'b0;
        copy_next     = 1'b0;
        irq_next      = 1'b0;
        refresh_next  = 1'b0;

        unique case (s3_beat_reg.cmd)
            lcdft_pkg::CMD_READ:
            begin
                unique case (s3_beat_reg.idx)
                    lcdft_pkg::REG_MODE:    rd_next = {2'b00, mode_reg} & lcdft_pkg::MODE_MASK;
                    lcdft_pkg::REG_RATE:    rd_next = rate_reg;
                    lcdft_pkg::REG_MAP_LO:  rd_next = map_base_reg[7:0] & lcdft_pkg::MAP_LO_MASK;
                    lcdft_pkg::REG_MAP_MID: rd_next = map_base_reg[15:8];
                    lcdft_pkg::REG_MAP_HI:
                        rd_next = {3'b000, map_base_reg[20:16]} & lcdft_pkg::HIGH_MASK;
                    lcdft_pkg::REG_SCR_Y:   rd_next = {1'b0, scroll_y_reg};
                    lcdft_pkg::REG_SCR_X:   rd_next = {1'b0, scroll_x_reg};
                    lcdft_pkg::REG_SPR_LO:  rd_next = spr_base_reg[7:0] & lcdft_pkg::SPR_LO_MASK;
                    lcdft_pkg::REG_SPR_MID: rd_next = spr_base_reg[15:8];
                    lcdft_pkg::REG_SPR_HI:
                        rd_next = {3'b000, spr_base_reg[20:16]} & lcdft_pkg::HIGH_MASK;
                    lcdft_pkg::REG_COUNTER: rd_next = fc_reg[31:24];
                    default:                rd_next = 8'h00;
                endcase
            end

            lcdft_pkg::CMD_WRITE:
            begin
                unique case (s3_beat_reg.idx)
                    lcdft_pkg::REG_MODE:
                    begin
                        mode_next = wdat[5:0];
                        if (!wdat[3])
                            draw_next = lcdft_pkg::DRAW_OFF;
                        else if (wdat[2] || wdat[1])
                            draw_next = lcdft_pkg::DRAW_FULL;
                        else
                            draw_next = lcdft_pkg::DRAW_COPY;
                    end
                    lcdft_pkg::REG_RATE:
                    begin
                        // a new divider restarts the skip count
                        if (rate_reg[3:1] != wdat[3:1])
                            rate_next = {4'h0, wdat[3:0]};
                        else
                            rate_next = {rate_reg[7:4], wdat[3:0]};
                        match_next = lcdft_pkg::rate_match_lut(wdat[3:1]);
                    end
                    lcdft_pkg::REG_MAP_LO:
                        map_base_next = {map_base_reg[20:8], wdat & lcdft_pkg::MAP_LO_MASK};
                    lcdft_pkg::REG_MAP_MID:
                        map_base_next = {map_base_reg[20:16], wdat, map_base_reg[7:0]};
                    lcdft_pkg::REG_MAP_HI:
                        map_base_next = {wdat[4:0], map_base_reg[15:0]};
                    lcdft_pkg::REG_SCR_Y:   scroll_y_next = wdat[6:0];
                    lcdft_pkg::REG_SCR_X:   scroll_x_next = wdat[6:0];
                    lcdft_pkg::REG_SPR_LO:
                        spr_base_next = {spr_base_reg[20:8], wdat & lcdft_pkg::SPR_LO_MASK};
                    lcdft_pkg::REG_SPR_MID:
                        spr_base_next = {spr_base_reg[20:16], wdat, spr_base_reg[7:0]};
                    lcdft_pkg::REG_SPR_HI:
                        spr_base_next = {wdat[4:0], spr_base_reg[15:0]};
                    default: ;
                endcase
            end

            lcdft_pkg::CMD_TICK:
            begin
                fc_next = fc_sum;
                if (frame_active)
                begin
                    if (fc_sum < lcdft_pkg::FC_RENDER)
                        phase_next = lcdft_pkg::PH_CPU;
                    else if (fc_sum[31:24] == lcdft_pkg::TOP_RENDER)
                    begin
                        // render point, full drawing only
                        if (phase_reg != lcdft_pkg::PH_RENDER
                            && draw_reg == lcdft_pkg::DRAW_FULL)
                        begin
                            stall_next  = 1'b1;
                            render_next = 1'b1;
                            phase_next  = lcdft_pkg::PH_RENDER;
                        end
                    end
                    else if (fc_sum[31:24] == lcdft_pkg::TOP_COPY)
                    begin
                        // copy point, copy or full drawing only
                        if (phase_reg != lcdft_pkg::PH_COPY
                            && draw_reg != lcdft_pkg::DRAW_OFF)
                        begin
                            stall_next = 1'b1;
                            copy_next  = 1'b1;
                            phase_next = lcdft_pkg::PH_COPY;
                        end
                    end
                    else if (fc_sum >= lcdft_pkg::FC_END)
                    begin
                        stall_next   = 1'b0;
                        rate_next    = {4'h0, rate_reg[3:0]};
                        fc_next      = lcdft_pkg::FC_RESTART;
                        irq_next     = 1'b1;
                        refresh_next = 1'b1;
                    end
                end
                else if (fc_sum >= lcdft_pkg::FC_END)
                begin
                    // skipped frame: bump the skip count, wraps in 8 bits
                    rate_next    = rate_reg + lcdft_pkg::SKIP_STEP;
                    fc_next      = lcdft_pkg::FC_RESTART;
                    refresh_next = 1'b1;
                end
            end

            default: ;
        endcase
    end

    // state updates only when a beat leaves stage 3 into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            rate_reg     <= '0;
            match_reg    <= lcdft_pkg::MATCH_RESET;
            draw_reg     <= lcdft_pkg::DRAW_OFF;
            map_base_reg <= '0;
            spr_base_reg <= '0;
            scroll_y_reg <= '0;
            scroll_x_reg <= '0;
            fc_reg       <= '0;
            phase_reg    <= lcdft_pkg::PH_CPU;
            stall_reg    <= 1'b0;
        end
        else if (adv && s3_vld_reg)
        begin
            mode_reg     <= mode_next;
            rate_reg     <= rate_next;
            match_reg    <= match_next;
            draw_reg     <= draw_next;
            map_base_reg <= map_base_next;
            spr_base_reg <= spr_base_next;
            scroll_y_reg <= scroll_y_next;
            scroll_x_reg <= scroll_x_next;
            fc_reg       <= fc_next;
            phase_reg    <= phase_next;
            stall_reg    <= stall_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg      <= rd_next;
            render_reg  <= render_next;
            copy_reg    <= copy_next;
            irq_reg     <= irq_next;
            refresh_reg <= refresh_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign read_data     = rd_reg;
    assign cpu_stall     = stall_reg;
    assign render_start  = render_reg;
    assign copy_start    = copy_reg;
    assign frame_end_irq = irq_reg;
    assign lcd_refresh   = refresh_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `LCDFT_ASSERT_IMP(a_refresh_restart, out_valid && lcd_refresh,
        fc_reg == lcdft_pkg::FC_RESTART, "refresh without counter restart")
    `LCDFT_ASSERT_IMP(a_irq_releases, out_valid && frame_end_irq,
        lcd_refresh && !cpu_stall, "frame end irq without refresh or with stall")
    `LCDFT_ASSERT_IMP(a_render_phase, out_valid && render_start,
        cpu_stall && phase_reg == lcdft_pkg::PH_RENDER, "render start out of phase")
    `LCDFT_ASSERT_IMP(a_one_event, out_valid,
        $onehot0({render_start, copy_start, frame_end_irq}), "more than one frame event")
    `LCDFT_ASSERT_NXT(a_hold_state, s3_vld_reg && !adv,
        $stable(fc_reg) && $stable(rate_reg), "state moved during a stall")

endmodule
